// ===== rtl/core/seconds_to_calendar_date_top_macros.svh =====
// Assertion macros for the seconds-to-calendar-date block.
`ifndef SECONDS_TO_CALENDAR_DATE_TOP_MACROS_SVH
`define SECONDS_TO_CALENDAR_DATE_TOP_MACROS_SVH

// checked only while out of reset
`define STC_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define STC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/stc_pkg.sv =====
// Shared types, constants and tables of the seconds-to-calendar-date block.
`default_nettype none

package stc_pkg;

  localparam int unsigned SEC_W    = 32;
  localparam int unsigned YEAR_W   = 12;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned SECOND_W = 6;

  localparam int unsigned DCNT_W = 15;  // day count, 1 .. 24856
  localparam int unsigned TOD_W  = 17;  // second of day
  localparam int unsigned HSEC_W = 12;  // second of hour
  localparam int unsigned CYC_W  = 5;   // four-year cycles
  localparam int unsigned POS_W  = 11;  // day within cycle
  localparam int unsigned DOY_W  = 9;
  localparam int unsigned YIC_W  = 3;

  localparam int unsigned PIPE_DEPTH = 6;

  typedef logic signed [SEC_W-1:0] sec_t;
  typedef logic [YEAR_W-1:0]       year_t;
  typedef logic [MONTH_W-1:0]      month_t;
  typedef logic [DAY_W-1:0]        mday_t;
  typedef logic [HOUR_W-1:0]       hour_t;
  typedef logic [MINUTE_W-1:0]     minute_t;
  typedef logic [SECOND_W-1:0]     second_t;
  typedef logic [DCNT_W-1:0]       dcnt_t;
  typedef logic [TOD_W-1:0]        tod_t;
  typedef logic [HSEC_W-1:0]       hsec_t;
  typedef logic [CYC_W-1:0]        cyc_t;
  typedef logic [POS_W-1:0]        pos_t;
  typedef logic [DOY_W-1:0]        doy_t;
  typedef logic [YIC_W-1:0]        yic_t;

  // seconds / 86400 = (seconds >> 7) / 675
  localparam int unsigned DAY_PRE_SHIFT = 7;
  localparam int unsigned DAY_IN_W      = 24;
  localparam int unsigned DAY_RECIP_W   = 25;
  localparam int unsigned DAY_SHIFT     = 34;
  localparam logic [DAY_RECIP_W-1:0] DAY_RECIP = 25'd25451659;
  localparam logic [TOD_W-1:0]       SECS_PER_DAY = 17'd86400;

  // second of day / 3600 = (tod >> 4) / 225
  localparam int unsigned HR_PRE_SHIFT = 4;
  localparam int unsigned HR_IN_W      = TOD_W - HR_PRE_SHIFT;
  localparam int unsigned HR_PROD_W    = 26;
  localparam int unsigned HR_SHIFT     = 20;
  localparam logic [HR_PROD_W-1:0] HR_RECIP = 26'd4661;
  localparam logic [TOD_W-1:0]     SECS_PER_HOUR = 17'd3600;

  // second of hour / 60 = (hsec >> 2) / 15
  localparam int unsigned MIN_PRE_SHIFT = 2;
  localparam int unsigned MIN_IN_W      = HSEC_W - MIN_PRE_SHIFT;
  localparam int unsigned MIN_PROD_W    = 21;
  localparam int unsigned MIN_SHIFT     = 14;
  localparam logic [MIN_PROD_W-1:0] MIN_RECIP = 21'd1093;
  localparam logic [HSEC_W-1:0]     SECS_PER_MIN = 12'd60;

  // day count / 1461
  localparam int unsigned CYC_PROD_W = 30;
  localparam int unsigned CYC_SHIFT  = 25;
  localparam logic [CYC_PROD_W-1:0] CYC_RECIP  = 30'd22967;
  localparam logic [DCNT_W-1:0]     CYCLE_DAYS = 15'd1461;

  localparam logic [POS_W-1:0] YEAR2_POS = 11'd367;
  localparam logic [POS_W-1:0] YEAR3_POS = 11'd732;
  localparam logic [POS_W-1:0] YEAR4_POS = 11'd1097;
  localparam logic [POS_W-1:0] YEAR2_OFS = 11'd366;
  localparam logic [POS_W-1:0] YEAR3_OFS = 11'd731;
  localparam logic [POS_W-1:0] YEAR4_OFS = 11'd1096;
  localparam logic [DOY_W-1:0] LAST_DOY  = 9'd365;
  localparam logic [DOY_W-1:0] FEB29_DOY = 9'd60;
  localparam logic [YEAR_W-1:0] BASE_YEAR = 12'd1999;

  localparam int unsigned      MONTHS     = 12;
  localparam logic [MONTH_W-1:0] FEB_MONTH = 4'd2;
  localparam logic [DAY_W-1:0]   LEAP_DAY  = 5'd29;

  localparam yic_t YIC_PREV  = 3'd0;
  localparam yic_t YIC_LEAP  = 3'd1;
  localparam yic_t YIC_2ND   = 3'd2;
  localparam yic_t YIC_3RD   = 3'd3;
  localparam yic_t YIC_4TH   = 3'd4;

  // days before the first of each month, common year
  function automatic doy_t month_start(input logic [MONTH_W-1:0] idx);
    doy_t r;
    case (idx)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd59;
      4'd3:    r = 9'd90;
      4'd4:    r = 9'd120;
      4'd5:    r = 9'd151;
      4'd6:    r = 9'd181;
      4'd7:    r = 9'd212;
      4'd8:    r = 9'd243;
      4'd9:    r = 9'd273;
      4'd10:   r = 9'd304;
      4'd11:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/stc_in_if.sv =====
// Input channel: one elapsed-seconds value per transaction.
`default_nettype none

interface stc_in_if;
  import stc_pkg::*;

  logic valid;
  logic ready;
  sec_t elapsed_seconds;

  modport source (output valid, output elapsed_seconds, input ready);
  modport sink   (input valid, input elapsed_seconds, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/stc_out_if.sv =====
// Output channel: one calendar date and time per transaction.
`default_nettype none

interface stc_out_if;
  import stc_pkg::*;

  logic    valid;
  logic    ready;
  year_t   cal_year;
  month_t  cal_month;
  mday_t   cal_day;
  hour_t   cal_hour;
  minute_t cal_minute;
  second_t cal_second;
  logic    range_error;

  modport source (output valid, output cal_year, output cal_month, output cal_day,
                  output cal_hour, output cal_minute, output cal_second,
                  output range_error, input ready);
  modport sink   (input valid, input cal_year, input cal_month, input cal_day,
                  input cal_hour, input cal_minute, input cal_second,
                  input range_error, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/stc_day_div.sv =====
// Stages 1-2: split seconds into day count and second of day.
`default_nettype none

module stc_day_div (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [30:0]   sec_i,
  output stc_pkg::dcnt_t day_cnt_o,
  output stc_pkg::tod_t  tod_o
);
  import stc_pkg::*;

  localparam int unsigned P1_W = DAY_IN_W + DAY_RECIP_W;
  localparam int unsigned P2_W = DCNT_W + TOD_W;

  logic [TOD_W-1:0] s1_lo_q;
  logic [P1_W-1:0]  p1_d, p1_q;
  dcnt_t            q_d, q2_q;
  logic [P2_W-1:0]  p2_d;
  tod_t             slo2_q, p2_q;

  assign p1_d = P1_W'(sec_i[30:DAY_PRE_SHIFT]) * P1_W'(DAY_RECIP);
  assign q_d  = p1_q[DAY_SHIFT +: DCNT_W];
  assign p2_d = P2_W'(q_d) * P2_W'(SECS_PER_DAY);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_lo_q <= sec_i[TOD_W-1:0];
      p1_q    <= p1_d;
      slo2_q  <= s1_lo_q;
      q2_q    <= q_d;
      p2_q    <= p2_d[TOD_W-1:0];
    end
  end

  // remainder is below 2^17, so the low bits of the difference are exact
  assign day_cnt_o = q2_q + DCNT_W'(1);
  assign tod_o     = slo2_q - p2_q;
endmodule

`default_nettype wire

// ===== rtl/core/stc_tod.sv =====
// Stages 3-6: second of day into hour, minute and second.
`default_nettype none

module stc_tod (
  input  logic             clk_i,
  input  logic             en_i,
  input  stc_pkg::tod_t    tod_i,
  output stc_pkg::hour_t   hour_o,
  output stc_pkg::minute_t minute_o,
  output stc_pkg::second_t second_o
);
  import stc_pkg::*;

  tod_t                  rem3_q, rem4_q;
  logic [HR_PROD_W-1:0]  phr3_q;
  hour_t                 hour_d, hour4_q, hour5_q, hour6_q;
  tod_t                  ph4_q;
  tod_t                  rem_diff;
  hsec_t                 hsec_d, hsec5_q;
  logic [MIN_PROD_W-1:0] pmin_d, pmin5_q;
  minute_t               minute_d, minute6_q;
  hsec_t                 min_secs;
  second_t               second_d, second6_q;

  assign hour_d   = phr3_q[HR_SHIFT +: HOUR_W];
  assign rem_diff = rem4_q - ph4_q;
  assign hsec_d   = rem_diff[HSEC_W-1:0];
  assign pmin_d   = MIN_PROD_W'(hsec_d[HSEC_W-1:MIN_PRE_SHIFT]) * MIN_RECIP;
  assign minute_d = pmin5_q[MIN_SHIFT +: MINUTE_W];
  assign min_secs = HSEC_W'(minute_d) * SECS_PER_MIN;
  assign second_d = SECOND_W'(hsec5_q - min_secs);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem3_q    <= tod_i;
      phr3_q    <= HR_PROD_W'(tod_i[TOD_W-1:HR_PRE_SHIFT]) * HR_RECIP;
      rem4_q    <= rem3_q;
      hour4_q   <= hour_d;
      ph4_q     <= TOD_W'(hour_d) * SECS_PER_HOUR;
      hour5_q   <= hour4_q;
      hsec5_q   <= hsec_d;
      pmin5_q   <= pmin_d;
      hour6_q   <= hour5_q;
      minute6_q <= minute_d;
      second6_q <= second_d;
    end
  end

  assign hour_o   = hour6_q;
  assign minute_o = minute6_q;
  assign second_o = second6_q;
endmodule

`default_nettype wire

// ===== rtl/core/stc_date.sv =====
// Stages 3-6: day count into year, month and day of month.
`default_nettype none

module stc_date (
  input  logic            clk_i,
  input  logic            en_i,
  input  stc_pkg::dcnt_t  day_cnt_i,
  output stc_pkg::year_t  year_o,
  output stc_pkg::month_t month_o,
  output stc_pkg::mday_t  day_o
);
  import stc_pkg::*;

  dcnt_t                 dc3_q, dc4_q;
  logic [CYC_PROD_W-1:0] pcyc3_q;
  cyc_t                  cyc_d, cyc4_q, cyc5_q;
  dcnt_t                 pc4_q;
  dcnt_t                 pos_diff;
  pos_t                  pos;
  yic_t                  yic_d, yic5_q;
  doy_t                  doy_d, doy5_q;
  logic                  leap_d, leap5_q;
  year_t                 year_d, year6_q;
  month_t                month_d, month6_q;
  mday_t                 day_d, day6_q;

  assign cyc_d    = pcyc3_q[CYC_SHIFT +: CYC_W];
  assign pos_diff = dc4_q - pc4_q;
  assign pos      = pos_diff[POS_W-1:0];

  always_comb begin
    yic_d  = YIC_4TH;
    doy_d  = DOY_W'(pos - YEAR4_OFS);
    leap_d = 1'b0;
    if (pos == '0) begin
      // last day of the previous cycle
      yic_d = YIC_PREV;
      doy_d = LAST_DOY;
    end else if (pos < YEAR2_POS) begin
      yic_d  = YIC_LEAP;
      doy_d  = DOY_W'(pos);
      leap_d = 1'b1;
    end else if (pos < YEAR3_POS) begin
      yic_d = YIC_2ND;
      doy_d = DOY_W'(pos - YEAR2_OFS);
    end else if (pos < YEAR4_POS) begin
      yic_d = YIC_3RD;
      doy_d = DOY_W'(pos - YEAR3_OFS);
    end
  end

  always_comb begin
    doy_t             d;
    logic [MONTH_W-1:0] m_idx;
    d = (leap5_q && (doy5_q > FEB29_DOY)) ? (doy5_q - DOY_W'(1)) : doy5_q;
    m_idx = '0;
    for (int k = 1; k < MONTHS; k++) begin
      if (d > month_start(MONTH_W'(k))) begin
        m_idx = MONTH_W'(k);
      end
    end
    if (leap5_q && (doy5_q == FEB29_DOY)) begin
      month_d = FEB_MONTH;
      day_d   = LEAP_DAY;
    end else begin
      month_d = m_idx + MONTH_W'(1);
      day_d   = DAY_W'(d - month_start(m_idx));
    end
    year_d = BASE_YEAR + (YEAR_W'(cyc5_q) << 2) + YEAR_W'(yic5_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dc3_q    <= day_cnt_i;
      pcyc3_q  <= CYC_PROD_W'(day_cnt_i) * CYC_RECIP;
      dc4_q    <= dc3_q;
      cyc4_q   <= cyc_d;
      pc4_q    <= DCNT_W'(cyc_d) * CYCLE_DAYS;
      cyc5_q   <= cyc4_q;
      yic5_q   <= yic_d;
      doy5_q   <= doy_d;
      leap5_q  <= leap_d;
      year6_q  <= year_d;
      month6_q <= month_d;
      day6_q   <= day_d;
    end
  end

  assign year_o  = year6_q;
  assign month_o = month6_q;
  assign day_o   = day6_q;
endmodule

`default_nettype wire

// ===== rtl/core/seconds_to_calendar_date_top.sv =====
// Top level: pipelined seconds-since-2000 to calendar date and time converter.
//
//   channel  dir  transaction
//   sec_i    in   elapsed_seconds (signed 32 bits)
//   date_o   out  cal_year, cal_month, cal_day, cal_hour, cal_minute,
//                 cal_second, range_error
//
// Six register stages; one transaction in and one out per cycle while date_o is not stalled.
// Three constant-reciprocal multiplies in series (day, hour/cycle, minute) set the depth.
// Reset clears the stage valid and error bits only; the pipeline is empty after reset.
// A stall at date_o freezes every stage; bubbles do not collapse.
`default_nettype none
`include "seconds_to_calendar_date_top_macros.svh"

module seconds_to_calendar_date_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  stc_in_if.sink    sec_i,
  stc_out_if.source date_o
);
  import stc_pkg::*;

  logic                  en;
  logic [PIPE_DEPTH-1:0] vld_q, vld_d;
  logic [PIPE_DEPTH-1:0] err_q, err_d;
  dcnt_t                 day_cnt;
  tod_t                  tod;
  year_t                 year;
  month_t                month;
  mday_t                 mday;
  hour_t                 hour;
  minute_t               minute;
  second_t               second;
  logic                  out_err;

  assign en          = !vld_q[PIPE_DEPTH-1] || date_o.ready;
  assign sec_i.ready = en;

  assign vld_d = {vld_q[PIPE_DEPTH-2:0], sec_i.valid};
  assign err_d = {err_q[PIPE_DEPTH-2:0], sec_i.elapsed_seconds[SEC_W-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      err_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
      err_q <= err_d;
    end
  end

  stc_day_div u_day_div (
    .clk_i     (clk_i),
    .en_i      (en),
    .sec_i     (sec_i.elapsed_seconds[SEC_W-2:0]),
    .day_cnt_o (day_cnt),
    .tod_o     (tod)
  );

  stc_tod u_tod (
    .clk_i    (clk_i),
    .en_i     (en),
    .tod_i    (tod),
    .hour_o   (hour),
    .minute_o (minute),
    .second_o (second)
  );

  stc_date u_date (
    .clk_i     (clk_i),
    .en_i      (en),
    .day_cnt_i (day_cnt),
    .year_o    (year),
    .month_o   (month),
    .day_o     (mday)
  );

  assign out_err            = err_q[PIPE_DEPTH-1];
  assign date_o.valid       = vld_q[PIPE_DEPTH-1];
  assign date_o.range_error = out_err;
  assign date_o.cal_year    = out_err ? '0 : year;
  assign date_o.cal_month   = out_err ? '0 : month;
  assign date_o.cal_day     = out_err ? '0 : mday;
  assign date_o.cal_hour    = out_err ? '0 : hour;
  assign date_o.cal_minute  = out_err ? '0 : minute;
  assign date_o.cal_second  = out_err ? '0 : second;

  `STC_ASSERT_ALWAYS(a_no_valid_in_reset, !rst_ni |=> !date_o.valid, "valid during reset")
  `STC_ASSERT_RUN(a_accept_enters,
    (sec_i.valid && sec_i.ready) |=>
      (vld_q[0] && (err_q[0] == $past(sec_i.elapsed_seconds[SEC_W-1]))),
    "accepted transaction lost at entry")
  `STC_ASSERT_RUN(a_fields_in_range,
    (date_o.valid && !date_o.range_error) |->
      (date_o.cal_month >= 4'd1 && date_o.cal_month <= 4'd12 && date_o.cal_day >= 5'd1 &&
       date_o.cal_hour <= 5'd23 && date_o.cal_minute <= 6'd59 && date_o.cal_second <= 6'd59),
    "date field out of range")
  `STC_ASSERT_RUN(a_leap_day_year,
    (date_o.valid && date_o.cal_month == FEB_MONTH && date_o.cal_day == LEAP_DAY) |->
      (date_o.cal_year[1:0] == 2'd0),
    "February 29 in a common year")
endmodule

`default_nettype wire

// ===== verif/date_checker.sv =====
`timescale 1ns / 100ps
// Checker: predicts the calendar date of every accepted seconds value and compares each result.
module date_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  stc_in_if           sec_mon,
  stc_out_if          date_mon,
  output int unsigned bad_dates_o,
  output int unsigned dates_due_o
);
  import stc_pkg::*;

  localparam int unsigned DAY_SECS   = 86400;
  localparam int unsigned HOUR_SECS  = 3600;
  localparam int unsigned MIN_SECS   = 60;
  localparam int unsigned QUAD_DAYS  = 1461;
  localparam int unsigned Y2_START   = 367;
  localparam int unsigned Y3_START   = 732;
  localparam int unsigned Y4_START   = 1097;
  localparam int unsigned LAST_YDAY  = 365;
  localparam int unsigned FEB29_YDAY = 60;
  localparam int unsigned FEBRUARY   = 2;
  localparam int unsigned LEAP_MDAY  = 29;
  localparam int unsigned ORIGIN_YR  = 1999;
  localparam int unsigned REPORT_MAX = 10;
  localparam int unsigned MONTH_OFS [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
                                             304, 334};

  typedef struct packed {
    year_t   year;
    month_t  month;
    mday_t   mday;
    hour_t   hour;
    minute_t minute;
    second_t second;
    logic    range_error;
  } cal_date_t;

  typedef struct {
    sec_t      secs;
    cal_date_t date;
  } due_date_t;

  due_date_t due_dates [$];

  function automatic cal_date_t calendar_of(input sec_t secs);
    int unsigned s, day_no, tod, quad, pos, yday, yr_ofs, mon, k;
    bit          leap;
    cal_date_t   d;
    d = '0;
    if (secs < 0) begin
      d.range_error = 1'b1;
      return d;
    end
    s      = secs;
    day_no = s / DAY_SECS + 1;
    tod    = s % DAY_SECS;
    quad   = day_no / QUAD_DAYS;
    pos    = day_no % QUAD_DAYS;
    leap   = 1'b0;
    if (pos == 0) begin
      yr_ofs = 0;
      yday   = LAST_YDAY;
    end else if (pos < Y2_START) begin
      yr_ofs = 1;
      leap   = 1'b1;
      yday   = pos;
    end else if (pos < Y3_START) begin
      yr_ofs = 2;
      yday   = pos - (Y2_START - 1);
    end else if (pos < Y4_START) begin
      yr_ofs = 3;
      yday   = pos - (Y3_START - 1);
    end else begin
      yr_ofs = 4;
      yday   = pos - (Y4_START - 1);
    end
    if (leap && yday == FEB29_YDAY) begin
      mon    = FEBRUARY;
      d.mday = mday_t'(LEAP_MDAY);
    end else begin
      if (leap && yday > FEB29_YDAY) yday--;
      mon = 1;
      for (k = 1; k < 12; k++) begin
        if (yday > MONTH_OFS[k]) mon = k + 1;
      end
      d.mday = mday_t'(yday - MONTH_OFS[mon-1]);
    end
    d.year   = year_t'(ORIGIN_YR + quad * 4 + yr_ofs);
    d.month  = month_t'(mon);
    d.hour   = hour_t'(tod / HOUR_SECS);
    d.minute = minute_t'((tod % HOUR_SECS) / MIN_SECS);
    d.second = second_t'(tod % MIN_SECS);
    return d;
  endfunction

  always @(posedge clk_i) begin : watch
    cal_date_t got;
    due_date_t due;
    if (rst_ni) begin
      if (date_mon.valid && date_mon.ready) begin
        got = {date_mon.cal_year, date_mon.cal_month, date_mon.cal_day, date_mon.cal_hour,
               date_mon.cal_minute, date_mon.cal_second, date_mon.range_error};
        if (due_dates.size() == 0) begin
          if (bad_dates_o < REPORT_MAX)
            $display("%0t: unexpected date transaction %0d-%0d-%0d %0d:%0d:%0d err %0b",
                     $realtime, got.year, got.month, got.mday, got.hour, got.minute,
                     got.second, got.range_error);
          bad_dates_o++;
        end else begin
          due = due_dates.pop_front();
          if (got !== due.date) begin
            if (bad_dates_o < REPORT_MAX) begin
              $write("%0t: secs %0d exp %0d-%0d-%0d %0d:%0d:%0d err %0b,",
                     $realtime, due.secs, due.date.year, due.date.month, due.date.mday,
                     due.date.hour, due.date.minute, due.date.second,
                     due.date.range_error);
              $display(" got %0d-%0d-%0d %0d:%0d:%0d err %0b",
                       got.year, got.month, got.mday, got.hour,
                       got.minute, got.second, got.range_error);
            end
            bad_dates_o++;
          end
        end
      end
      if (sec_mon.valid && sec_mon.ready)
        due_dates.push_back('{sec_mon.elapsed_seconds, calendar_of(sec_mon.elapsed_seconds)});
    end
    dates_due_o = due_dates.size();
  end

endmodule

// ===== verif/tb_seconds_to_calendar_date_top.sv =====
`timescale 1ns / 100ps
// Testbench top: drives seconds values, stalls the date channel and gives the verdict.
module tb_seconds_to_calendar_date_top;
  import stc_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 750;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DAY_SECS     = 86400;
  localparam int unsigned QUAD_DAYS    = 1461;
  localparam int unsigned N_CORNERS    = 25;
  localparam int unsigned EDGE_DAYS [10] = '{0, 59, 60, 365, 366, 730, 731, 1095, 1096, 1460};
  localparam sec_t CORNER_SECS [N_CORNERS] = '{
    32'sd0, 32'sd1, 32'sd59, 32'sd60, 32'sd3600, 32'sd86400,
    32'sd5097599, 32'sd5097600, 32'sd5183999, 32'sd5184000,
    32'sd31536000, 32'sd31622400, 32'sd63072000, 32'sd63158400,
    32'sd94608000, 32'sd94694400, 32'sd126144000, 32'sd126230399, 32'sd126230400,
    32'sd131328000, 32'sh7fff_ffff,
    -32'sd1, -32'sd86399, -32'sd86400, 32'sh8000_0000
  };

  typedef enum logic [1:0] {RX_FLOW, RX_MOSTLY, RX_SPARSE, RX_PATTERN} rx_mode_e;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned bad_dates;
  int unsigned dates_due;
  int unsigned hold_requests = 0;
  int unsigned burst_left    = 0;
  int unsigned cycle_cnt     = 0;

  stc_in_if  sec_if ();
  stc_out_if date_if ();

  seconds_to_calendar_date_top DUT (
    .clk_i,
    .rst_ni,
    .sec_i  (sec_if),
    .date_o (date_if)
  );

  date_checker u_date_checker (
    .clk_i,
    .rst_ni,
    .sec_mon     (sec_if),
    .date_mon    (date_if),
    .bad_dates_o (bad_dates),
    .dates_due_o (dates_due)
  );

  always #4 clk_i = ~clk_i;

  function automatic sec_t random_seconds();
    int unsigned sel;
    int          jit;
    longint      v;
    sel = $urandom_range(0, 9);
    if (sel < 3) return sec_t'($urandom);
    if (sel < 6) return sec_t'($urandom & 32'h7fff_ffff);
    if (sel == 9) return -sec_t'($urandom_range(1, DAY_SECS - 1));
    // around year and cycle boundaries
    jit = int'($urandom_range(0, 2)) - 1;
    v   = longint'($urandom_range(0, 16)) * QUAD_DAYS;
    v   = v + longint'(EDGE_DAYS[$urandom_range(0, 9)]) + jit;
    v   = v * DAY_SECS + longint'($urandom_range(0, DAY_SECS - 1));
    if (v < 0) v = 0;
    if (v > longint'(32'h7fff_ffff)) v = longint'(32'h7fff_ffff);
    return sec_t'(v);
  endfunction

  task automatic pause(input int unsigned n);
    @(negedge clk_i);
    sec_if.valid           <= 1'b0;
    sec_if.elapsed_seconds <= $urandom;
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic offer(input sec_t secs, input bit gaps);
    @(negedge clk_i);
    sec_if.valid           <= 1'b1;
    sec_if.elapsed_seconds <= secs;
    do @(posedge clk_i); while (sec_if.ready !== 1'b1);
    if (burst_left != 0) burst_left--;
    if (gaps && burst_left == 0) begin
      pause($urandom_range(1, 12));
      burst_left = $urandom_range(1, 40);
    end
  endtask

  task automatic wait_drained();
    pause(1);
    while (dates_due != 0) @(negedge clk_i);
  endtask

  initial begin : date_sink
    rx_mode_e    mode;
    int unsigned mode_left, hold_left, holds_done, phase;
    logic [7:0]  pat;
    mode         = RX_FLOW;
    mode_left    = 0;
    hold_left    = 0;
    holds_done   = 0;
    phase        = 0;
    pat          = '1;
    date_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_requests != holds_done) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (!rst_ni) begin
        date_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        date_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 160);
          pat       = $urandom;
        end
        mode_left--;
        case (mode)
          RX_FLOW:   date_if.ready <= 1'b1;
          RX_MOSTLY: date_if.ready <= ($urandom_range(0, 3) != 0);
          RX_SPARSE: date_if.ready <= ($urandom_range(0, 3) == 0);
          default: begin
            date_if.ready <= pat[phase % 8];
            phase++;
          end
        endcase
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int unsigned k;
    sec_if.valid           = 1'b0;
    sec_if.elapsed_seconds = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (k = 0; k < N_CORNERS; k++) offer(CORNER_SECS[k], 1'b1);
    wait_drained();

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      // long output hold while input keeps coming without gaps
      if (k == 250 || k == 600) hold_requests++;
      offer(random_seconds(), !((k >= 250 && k < 290) || (k >= 600 && k < 640)));
      if (k == 450) wait_drained();
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (bad_dates == 0 && dates_due == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
